// ----- rtl/srg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srg_pkg
// Shared types, constants and helpers of the subtractive random generator.
// ----------------------------------------------------------------------------
package srg_pkg;

  // Table geometry: positions 1..55 live at addresses 0..54
  localparam int unsigned TabLen = 55;
  localparam int unsigned TabAw  = 6;
  localparam logic [TabAw-1:0] LastAddr  = 6'd54;
  localparam logic [TabAw-1:0] FillStep  = 6'd21;
  localparam logic [TabAw-1:0] TrailInit = 6'd31;
  // mixing partner of position i is 1 + (i + 30) mod 55, i.e. address + 31
  localparam logic [TabAw-1:0] MixLag    = 6'd31;

  localparam logic [29:0] ModBig   = 30'd1000000000;
  localparam logic [27:0] SeedBase = 28'd161803398;

  // Configuration register indexes
  localparam logic [1:0] CfgSeed   = 2'd0;
  localparam logic [1:0] CfgWarmup = 2'd1;

  typedef struct packed {
    logic             we;
    logic [TabAw-1:0] waddr;
    logic [29:0]      wdata;
    logic [TabAw-1:0] raddr_a;
    logic [TabAw-1:0] raddr_b;
  } tbl_req_t;

  typedef struct packed {
    logic        start;
    logic [30:0] limit;
    logic [29:0] raw;
  } scl_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [29:0] raw;
    logic [30:0] scaled;
  } scl_rsp_t;

  // a - b modulo 10^9, both operands below 10^9
  function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
    logic [30:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      t = t + {1'b0, ModBig};
    end
    return t[29:0];
  endfunction

  // (a + inc) mod 55 for a, inc below 55
  function automatic logic [TabAw-1:0] add_mod55(input logic [TabAw-1:0] a,
                                                 input logic [TabAw-1:0] inc);
    logic [TabAw:0] s;
    s = {1'b0, a} + {1'b0, inc};
    if (s >= 7'(TabLen)) begin
      s = s - 7'(TabLen);
    end
    return s[TabAw-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/subtractive_random_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Lagged subtractive generator mod 10^9 over a 55-word table.
// ----------------------------------------------------------------------------
// Use: each item on the input channel (range_limit_i) is one draw and gives
// one item on the output channel: raw_value_o in 0..10^9-1 and
// scaled_value_o = floor(range_limit * raw / 10^9) + 1, or 0 for a zero limit.
// Configuration (index 0 seed, index 1 warm-up count) is written over the
// cfg channel while the block is idle; a write to either index forces a
// reseed on the next draw.
// Sequence: a seeded draw reads the table and writes back the new word,
// then runs the scaler (two partial products, sum, reciprocal estimate,
// back-multiply, correction) and is loaded into the output register. No
// new item is taken until the current one has been loaded. A draw that
// reseeds first runs the table fill (55 words), the mixing (4 passes x 55
// read/write steps) and a table read and write-back per warm-up draw.
// Reset: control state clears, the table is left as is and marked unseeded.
// Output stall: the finished item waits in the output register; a new item
// may already be accepted and computed, but it is not loaded until the
// waiting item is taken.
// ----------------------------------------------------------------------------
module subtractive_random_generator
  import srg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // draw requests
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [30:0] range_limit_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [29:0] raw_value_o,
  output logic      [30:0] scaled_value_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [27:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_SCALE
  } ctl_state_e;

  ctl_state_e       state_q;
  logic             seeded_q;
  logic [27:0]      seed_q;
  logic [7:0]       warm_q;
  logic [7:0]       warm_cnt_q;
  logic [TabAw-1:0] lead_q;
  logic [TabAw-1:0] trail_q;
  logic [TabAw-1:0] fill_cnt_q;
  logic [TabAw-1:0] fill_pos_q;
  logic [TabAw-1:0] mix_addr_q;
  logic [1:0]       mix_pass_q;
  logic [29:0]      j_q;
  logic [29:0]      k_q;
  logic [30:0]      limit_q;
  logic             out_valid_q;
  logic [29:0]      raw_out_q;
  logic [30:0]      scaled_out_q;

  tbl_req_t    tbl_req;
  logic [29:0] rd_a;
  logic [29:0] rd_b;
  scl_req_t    scl_req;
  scl_rsp_t    scl_rsp;

  logic             in_acc_w;
  logic             cfg_acc_w;
  logic             out_free_w;
  logic             load_w;
  logic [29:0]      diff_w;
  logic [29:0]      seed_word_w;
  logic [27:0]      seed_sat_w;
  logic [TabAw-1:0] mix_b_w;

  srg_table_ram u_table (
    .clk_i  (clk_i),
    .req_i  (tbl_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  srg_scaler u_scaler (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (scl_req),
    .rsp_o  (scl_rsp)
  );

  // a pending config write goes first
  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc_w    = in_valid_i && !in_stall_o;
  assign cfg_acc_w   = cfg_valid_i && cfg_ready_o;
  assign out_free_w  = !out_valid_q || !out_stall_i;
  assign load_w      = (state_q == ST_SCALE) && scl_rsp.done && out_free_w;

  assign diff_w      = sub_mod(rd_a, rd_b);
  assign seed_sat_w  = (seed_q > SeedBase) ? SeedBase : seed_q;
  assign seed_word_w = {2'b00, SeedBase - seed_sat_w};
  assign mix_b_w     = add_mod55(mix_addr_q, MixLag);

  always_comb begin
    tbl_req = '0;
    unique case (state_q)
      ST_FILL: begin
        tbl_req.we = 1'b1;
        if (fill_cnt_q == '0) begin
          tbl_req.waddr = LastAddr;
          tbl_req.wdata = j_q;
        end else begin
          tbl_req.waddr = fill_pos_q - 6'd1;
          tbl_req.wdata = k_q;
        end
      end
      ST_MIX_RD: begin
        tbl_req.raddr_a = mix_addr_q;
        tbl_req.raddr_b = mix_b_w;
      end
      ST_MIX_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = mix_addr_q;
        tbl_req.wdata = diff_w;
      end
      ST_DRAW_RD: begin
        tbl_req.raddr_a = lead_q;
        tbl_req.raddr_b = trail_q;
      end
      ST_DRAW_WR: begin
        tbl_req.we    = 1'b1;
        tbl_req.waddr = lead_q;
        tbl_req.wdata = diff_w;
      end
      default: tbl_req = '0;
    endcase
  end

  assign scl_req.start = (state_q == ST_DRAW_WR) && (warm_cnt_q == '0);
  assign scl_req.limit = limit_q;
  assign scl_req.raw   = diff_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seeded_q     <= 1'b0;
      seed_q       <= 28'd1;
      warm_q       <= '0;
      warm_cnt_q   <= '0;
      lead_q       <= '0;
      trail_q      <= TrailInit;
      fill_cnt_q   <= '0;
      fill_pos_q   <= '0;
      mix_addr_q   <= '0;
      mix_pass_q   <= '0;
      j_q          <= '0;
      k_q          <= '0;
      limit_q      <= '0;
      out_valid_q  <= 1'b0;
      raw_out_q    <= '0;
      scaled_out_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !load_w) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_acc_w) begin
        unique case (cfg_index_i)
          CfgSeed: begin
            seed_q   <= cfg_data_i;
            seeded_q <= 1'b0;
          end
          CfgWarmup: begin
            warm_q   <= cfg_data_i[7:0];
            seeded_q <= 1'b0;
          end
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc_w) begin
            limit_q <= range_limit_i;
            if (seeded_q) begin
              state_q <= ST_DRAW_RD;
            end else begin
              j_q        <= seed_word_w;
              k_q        <= 30'd1;
              fill_cnt_q <= '0;
              fill_pos_q <= FillStep;
              state_q    <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          // the first fill step places the seed word at the last position
          if (fill_cnt_q != '0) begin
            k_q        <= sub_mod(j_q, k_q);
            j_q        <= k_q;
            fill_pos_q <= add_mod55(fill_pos_q, FillStep);
          end
          if (fill_cnt_q == LastAddr) begin
            mix_addr_q <= '0;
            mix_pass_q <= '0;
            state_q    <= ST_MIX_RD;
          end else begin
            fill_cnt_q <= fill_cnt_q + 6'd1;
          end
        end
        ST_MIX_RD: begin
          state_q <= ST_MIX_WR;
        end
        ST_MIX_WR: begin
          if (mix_addr_q == LastAddr) begin
            mix_addr_q <= '0;
            mix_pass_q <= mix_pass_q + 2'd1;
            if (mix_pass_q == 2'd3) begin
              lead_q     <= '0;
              trail_q    <= TrailInit;
              seeded_q   <= 1'b1;
              warm_cnt_q <= warm_q;
              state_q    <= ST_DRAW_RD;
            end else begin
              state_q <= ST_MIX_RD;
            end
          end else begin
            mix_addr_q <= mix_addr_q + 6'd1;
            state_q    <= ST_MIX_RD;
          end
        end
        ST_DRAW_RD: begin
          state_q <= ST_DRAW_WR;
        end
        ST_DRAW_WR: begin
          lead_q  <= (lead_q == LastAddr) ? '0 : lead_q + 6'd1;
          trail_q <= (trail_q == LastAddr) ? '0 : trail_q + 6'd1;
          if (warm_cnt_q != '0) begin
            warm_cnt_q <= warm_cnt_q - 8'd1;
            state_q    <= ST_DRAW_RD;
          end else begin
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (load_w) begin
            out_valid_q  <= 1'b1;
            raw_out_q    <= scl_rsp.raw;
            scaled_out_q <= scl_rsp.scaled;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign raw_value_o    = raw_out_q;
  assign scaled_value_o = scaled_out_q;

`ifndef ASSERT_OFF
  // lead and trail pointers keep their fixed lag of 31 positions
  a_lag_distance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lead_q < 6'd24) ? (trail_q == lead_q + 6'd31) : (trail_q == lead_q - 6'd24)))
    else $error("lead/trail lag broken");

  a_waddr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.we |-> (tbl_req.waddr <= LastAddr))
    else $error("table write out of range");

  a_idle_scaler : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !scl_rsp.busy)
    else $error("scaler busy while idle");

  // loaded result lies in 1..limit, or is zero for a zero limit
  a_scaled_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_w |=> ((scaled_value_o <= limit_q) && (raw_value_o < ModBig) &&
                ((scaled_value_o == '0) == (limit_q == '0))))
    else $error("scaled result out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/srg_table_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srg_table_ram
// 55 x 30 lag table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module srg_table_ram
  import srg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire tbl_req_t    req_i,
  output logic      [29:0] rd_a_o,
  output logic      [29:0] rd_b_o
);

  logic [29:0] mem_q [TabLen];
  logic [29:0] rd_a_q;
  logic [29:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem_q[req_i.raddr_a];
    rd_b_q <= mem_q[req_i.raddr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule
`default_nettype wire

// ----- rtl/srg_scaler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srg_scaler
// floor(limit * raw / 10^9) + 1: two 31x15 partial products, one sum,
// a reciprocal estimate of the quotient, then a back-multiply and a 0..2 fix.
// ----------------------------------------------------------------------------
module srg_scaler
  import srg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire scl_req_t req_i,
  output scl_rsp_t      rsp_o
);

  // floor(2^61 / 10^9); the estimate from the top 32 product bits is 0..2 low
  localparam logic [31:0] Recip  = 32'd2305843009;
  localparam logic [31:0] DivOne = {2'b00, ModBig};
  localparam logic [31:0] DivTwo = {1'b0, ModBig, 1'b0};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MLO,
    S_MHI,
    S_SUM,
    S_RCP,
    S_BACK,
    S_FIX,
    S_DONE
  } scl_state_e;

  scl_state_e  state_q;
  logic [30:0] limit_q;
  logic [29:0] raw_q;
  logic [45:0] pp_lo_q;
  logic [45:0] pp_hi_q;
  logic [60:0] prod_q;
  logic [30:0] quo_q;
  logic [31:0] back_q;

  logic [60:0] sum_w;
  logic [63:0] est_w;
  logic [31:0] back_w;
  logic [31:0] rem_w;

  assign sum_w  = {15'd0, pp_lo_q} + {pp_hi_q, 15'd0};
  assign est_w  = 64'(prod_q[60:29]) * 64'(Recip);
  // remainder is below 3 * 10^9, so the low 32 bits carry it exactly
  assign back_w = 32'(quo_q) * DivOne;
  assign rem_w  = prod_q[31:0] - back_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= '0;
      raw_q   <= '0;
      pp_lo_q <= '0;
      pp_hi_q <= '0;
      prod_q  <= '0;
      quo_q   <= '0;
      back_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE, S_DONE: begin
          if (req_i.start) begin
            limit_q <= req_i.limit;
            raw_q   <= req_i.raw;
            state_q <= S_MLO;
          end
        end
        S_MLO: begin
          pp_lo_q <= 46'(limit_q) * 46'(raw_q[14:0]);
          state_q <= S_MHI;
        end
        S_MHI: begin
          pp_hi_q <= 46'(limit_q) * 46'(raw_q[29:15]);
          state_q <= S_SUM;
        end
        S_SUM: begin
          prod_q  <= sum_w;
          state_q <= S_RCP;
        end
        S_RCP: begin
          // quotient fits 31 bits and the estimate never overshoots it
          quo_q   <= est_w[62:32];
          state_q <= S_BACK;
        end
        S_BACK: begin
          back_q  <= back_w;
          state_q <= S_FIX;
        end
        S_FIX: begin
          if (rem_w >= DivTwo) begin
            quo_q <= quo_q + 31'd2;
          end else if (rem_w >= DivOne) begin
            quo_q <= quo_q + 31'd1;
          end
          state_q <= S_DONE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.busy   = (state_q != S_IDLE) && (state_q != S_DONE);
  assign rsp_o.done   = (state_q == S_DONE);
  assign rsp_o.raw    = raw_q;
  assign rsp_o.scaled = (limit_q == '0) ? '0 : quo_q + 31'd1;

endmodule
`default_nettype wire
